// ===== rtl/brfo_pkg.sv =====
// Package for the byte ring FIFO with overwrite.
// Holds the operation and fill codes and the per-request result struct.
// No dependencies.
package brfo_pkg;

    localparam int DATA_W = 8;
    localparam int CNT_W  = 9;
    localparam int OP_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUT     = 2'd0,
        OP_PUT_OVR = 2'd1,
        OP_GET     = 2'd2,
        OP_FLUSH   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        FILL_EMPTY = 2'd0,
        FILL_PART  = 2'd1,
        FILL_FULL  = 2'd2
    } t_fill;

    typedef struct packed {
        logic             accepted;
        logic             get_ok;
        t_fill            fill_status;
        logic [CNT_W-1:0] data_count;
        logic [CNT_W-1:0] free_count;
    } t_result;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_req;

endpackage

// ===== rtl/brfo_ifs.sv =====
// Valid/ready channel interfaces of the byte ring FIFO: requests, results and
// the used-size configuration write. Depends on brfo_pkg for field widths.
interface brfo_in_if;
    logic                        valid;
    logic                        ready;
    logic [brfo_pkg::OP_W-1:0]   op;
    logic [brfo_pkg::DATA_W-1:0] data_in;

    modport source (output valid, output op, output data_in, input ready);
    modport sink   (input valid, input op, input data_in, output ready);
endinterface

interface brfo_out_if;
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic [brfo_pkg::DATA_W-1:0] data_out;
    logic [1:0]                  fill_status;
    logic [brfo_pkg::CNT_W-1:0]  data_count;
    logic [brfo_pkg::CNT_W-1:0]  free_count;

    modport source (output valid, output accepted, output data_out, output fill_status,
                    output data_count, output free_count, input ready);
    modport sink   (input valid, input accepted, input data_out, input fill_status,
                    input data_count, input free_count, output ready);
endinterface

interface brfo_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [brfo_pkg::CNT_W-1:0] used_size;

    modport source (output valid, output used_size, input ready);
    modport sink   (input valid, input used_size, output ready);
endinterface

// ===== rtl/byte_ring_fifo_with_overwrite_unit.sv =====
// Byte ring FIFO with overwrite. A result is registered and appears in the cycle after
// its request. One request per cycle; the output register takes a new result whenever
// it is empty or its result is taken in the same cycle. The store is a one-write,
// one-read memory whose registered read gives the byte of a get. Reset clears the
// pointers and wrap bits and sets the used size to DEPTH; the store is not cleared
// and needs no clearing pass. Depends on brfo_pkg, brfo_ifs, brfo_ctrl, brfo_mem.
module byte_ring_fifo_with_overwrite_unit #(
    parameter int DEPTH = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    brfo_in_if.sink      i_in,
    brfo_cfg_if.sink     i_cfg,
    brfo_out_if.source   o_out
);

    localparam int PW = $clog2(DEPTH);

    brfo_pkg::t_mem_req mem_req;
    brfo_pkg::t_result  res;
    brfo_pkg::t_result  r_res;
    logic               r_out_valid;
    logic [PW-1:0]      wr_addr, rd_addr;
    logic [7:0]         rd_data;
    logic               step;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign step        = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    brfo_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_op       (i_in.op),
        .i_cfg_wr   (i_cfg.valid),
        .i_cfg_size (i_cfg.used_size),
        .o_mem_req  (mem_req),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr),
        .o_res      (res)
    );

    brfo_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.data_in),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.accepted    = r_res.accepted;
    assign o_out.data_out    = r_res.get_ok ? rd_data : 8'd0;
    assign o_out.fill_status = r_res.fill_status;
    assign o_out.data_count  = r_res.data_count;
    assign o_out.free_count  = r_res.free_count;

endmodule

// ===== rtl/brfo_mem.sv =====
// Byte store of the ring FIFO: one write port and one registered read port.
// No package dependencies.
module brfo_mem #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]               i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [7:0]               o_rd_data
);

    logic [7:0] r_store [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store[i_wr_addr] <= i_wr_data;
        end
    end

    // The read data holds between gets, so a stalled result keeps its byte.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_store[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/brfo_ctrl.sv =====
// Pointer and wrap-bit control of the ring FIFO: decodes each request, steps
// the pointers and computes the status after the step. Depends on brfo_pkg.
module brfo_ctrl #(
    parameter int DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [brfo_pkg::OP_W-1:0]     i_op,
    input  logic                          i_cfg_wr,
    input  logic [brfo_pkg::CNT_W-1:0]    i_cfg_size,
    output brfo_pkg::t_mem_req            o_mem_req,
    output logic [$clog2(DEPTH)-1:0]      o_wr_addr,
    output logic [$clog2(DEPTH)-1:0]      o_rd_addr,
    output brfo_pkg::t_result             o_res
);

    localparam int PW = $clog2(DEPTH);
    localparam int DW = $clog2(DEPTH + 1);
    localparam int UW = (DW > brfo_pkg::CNT_W) ? DW : brfo_pkg::CNT_W;

    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic          r_rd_wrap, n_rd_wrap;
    logic          r_wr_wrap, n_wr_wrap;
    logic [UW-1:0] r_used, n_used;

    brfo_pkg::t_op op;
    logic [UW-1:0] count, new_count, last_idx, cfg_size_w;
    logic          full, empty, wr_last, rd_last;
    logic          do_wr, do_rd, do_flush, ok;
    logic [PW-1:0] wr_step, rd_step;

    assign op = brfo_pkg::t_op'(i_op);

    always_comb begin
        if (r_rd_ptr == r_wr_ptr) begin
            count = (r_rd_wrap == r_wr_wrap) ? '0 : r_used;
        end else if (r_wr_ptr > r_rd_ptr) begin
            count = UW'(r_wr_ptr) - UW'(r_rd_ptr);
        end else begin
            count = r_used - (UW'(r_rd_ptr) - UW'(r_wr_ptr));
        end
    end

    assign full     = (count == r_used);
    assign empty    = (count == '0);
    assign last_idx = r_used - UW'(1);
    assign wr_last  = (UW'(r_wr_ptr) >= last_idx);
    assign rd_last  = (UW'(r_rd_ptr) >= last_idx);
    assign wr_step  = wr_last ? '0 : r_wr_ptr + PW'(1);
    assign rd_step  = rd_last ? '0 : r_rd_ptr + PW'(1);

    always_comb begin
        do_wr     = 1'b0;
        do_rd     = 1'b0;
        do_flush  = 1'b0;
        ok        = 1'b0;
        new_count = count;
        unique case (op)
            brfo_pkg::OP_PUT: begin
                do_wr = !full;
                ok    = !full;
                if (!full) begin
                    new_count = count + UW'(1);
                end
            end
            brfo_pkg::OP_PUT_OVR: begin
                // When full the oldest byte is dropped, so the count stays.
                do_wr = 1'b1;
                do_rd = full;
                ok    = 1'b1;
                if (!full) begin
                    new_count = count + UW'(1);
                end
            end
            brfo_pkg::OP_GET: begin
                do_rd = !empty;
                ok    = !empty;
                if (!empty) begin
                    new_count = count - UW'(1);
                end
            end
            brfo_pkg::OP_FLUSH: begin
                do_flush  = 1'b1;
                ok        = 1'b1;
                new_count = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // A written size of zero means one entry; anything above the store depth is clipped.
    always_comb begin
        cfg_size_w = UW'(i_cfg_size);
        if (cfg_size_w == '0) begin
            cfg_size_w = UW'(1);
        end else if (cfg_size_w > UW'(DEPTH)) begin
            cfg_size_w = UW'(DEPTH);
        end
    end

    always_comb begin
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_rd_wrap = r_rd_wrap;
        n_wr_wrap = r_wr_wrap;
        n_used    = r_used;
        if (i_cfg_wr) begin
            n_used    = cfg_size_w;
            n_rd_ptr  = '0;
            n_wr_ptr  = '0;
            n_rd_wrap = 1'b0;
            n_wr_wrap = 1'b0;
        end else if (i_step) begin
            if (do_flush) begin
                n_rd_ptr  = '0;
                n_wr_ptr  = '0;
                n_rd_wrap = 1'b0;
                n_wr_wrap = 1'b0;
            end else begin
                if (do_wr) begin
                    n_wr_ptr  = wr_step;
                    n_wr_wrap = r_wr_wrap ^ wr_last;
                end
                if (do_rd) begin
                    n_rd_ptr  = rd_step;
                    n_rd_wrap = r_rd_wrap ^ rd_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_rd_wrap <= 1'b0;
            r_wr_wrap <= 1'b0;
            r_used    <= UW'(DEPTH);
        end else begin
            r_rd_ptr  <= n_rd_ptr;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_wrap <= n_rd_wrap;
            r_wr_wrap <= n_wr_wrap;
            r_used    <= n_used;
        end
    end

    always_comb begin
        o_mem_req.wr_en = i_step && do_wr;
        o_mem_req.rd_en = i_step && (op == brfo_pkg::OP_GET) && !empty;
        o_wr_addr       = r_wr_ptr;
        o_rd_addr       = r_rd_ptr;

        o_res.accepted   = ok;
        o_res.get_ok     = (op == brfo_pkg::OP_GET) && !empty;
        o_res.data_count = brfo_pkg::CNT_W'(new_count);
        o_res.free_count = brfo_pkg::CNT_W'(r_used - new_count);
        if (new_count == '0) begin
            o_res.fill_status = brfo_pkg::FILL_EMPTY;
        end else if (new_count == r_used) begin
            o_res.fill_status = brfo_pkg::FILL_FULL;
        end else begin
            o_res.fill_status = brfo_pkg::FILL_PART;
        end
    end

endmodule

// ===== rtl/brfo_checker.sv =====
// Port-level checks of the byte ring FIFO and the bind that attaches them to the
// top level. Depends on brfo_pkg and byte_ring_fifo_with_overwrite_unit.
module brfo_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_accepted,
    input logic [7:0] i_data_out,
    input logic [1:0] i_fill_status,
    input logic [8:0] i_data_count,
    input logic [8:0] i_free_count
);

    // Every accepted request produces a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("request accepted without a result on the next cycle");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_fill_status == brfo_pkg::FILL_EMPTY) == (i_data_count == 9'd0)))
        else $error("empty status disagrees with the byte count");

    a_full_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_fill_status == brfo_pkg::FILL_FULL) |-> (i_free_count == 9'd0))
        else $error("full status with free entries left");

    a_refused_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_accepted) |-> (i_data_out == 8'd0))
        else $error("refused request returned data");

endmodule

bind byte_ring_fifo_with_overwrite_unit brfo_checker u_brfo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_accepted    (o_out.accepted),
    .i_data_out    (o_out.data_out),
    .i_fill_status (o_out.fill_status),
    .i_data_count  (o_out.data_count),
    .i_free_count  (o_out.free_count)
);
